FILE: rtl/multichannel_pwm_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTICHANNEL_PWM_SCHEDULER_ASSERT_SVH
`define MULTICHANNEL_PWM_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants of the multichannel PWM scheduler.
// ----------------------------------------------------------------------------
package mps_pkg;

	localparam int          CHANNELS_DEF     = 32;
	localparam int          CATCHUP_MAX_DEF  = 4;
	localparam int          DEFAULT_HALF_DEF = 40000;
	localparam logic [30:0] MAX_WAIT_RESET   = 31'd20000000;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_WRITE   = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_NONE    = 2'd3
	} mps_req_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now;
		logic [4:0]  channel;
		logic [31:0] period;
		logic [31:0] high_time;
		logic [31:0] enable_bits;
	} mps_in_t;

	typedef struct packed {
		logic [31:0] pin_levels;
		logic        pins_changed;
		logic [31:0] next_event;
		logic        lagging;
		logic [31:0] enable_readback;
	} mps_out_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic restart;
		logic write;
		logic start;
		logic step;
		logic commit;
	} mps_cmd_t;

	// Per-cell tick outcome.
	typedef struct packed {
		logic set;
		logic clr;
		logic lag;
	} mps_flags_t;

endpackage

FILE: rtl/mps_cell.sv
// ----------------------------------------------------------------------------
// mps_cell
// One PWM channel: timings, edge time, level, one catch-up step per cycle
// and one stage of the next-event minimum chain.
// ----------------------------------------------------------------------------
`include "multichannel_pwm_scheduler_assert.svh"

module mps_cell #(
	parameter int DEFAULT_HALF = mps_pkg::DEFAULT_HALF_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mps_pkg::mps_cmd_t   cmd,
	input  logic                en,
	input  logic                wr_hit,
	input  logic [31:0]         wr_high,
	input  logic [31:0]         wr_low,
	input  logic [31:0]         now,
	input  logic [31:0]         min_in,
	output logic [31:0]         min_out,
	output mps_pkg::mps_flags_t flags
);

	localparam logic [31:0] HALF = 32'(DEFAULT_HALF);

	logic [31:0] stored_high_q, stored_low_q, run_high_q, run_low_q, edge_q;
	logic [31:0] d_q, min_q;
	logic        level_q, set_q, clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_high_q <= HALF;
			stored_low_q  <= HALF;
			run_high_q    <= HALF;
			run_low_q     <= HALF;
			edge_q        <= '0;
			level_q       <= 1'b0;
			set_q         <= 1'b0;
			clr_q         <= 1'b0;
		end else begin
			if (cmd.write && wr_hit) begin
				stored_high_q <= wr_high;
				stored_low_q  <= wr_low;
			end
			if (cmd.restart) begin
				level_q <= 1'b0;
				if (en) begin
					run_high_q <= stored_high_q;
					run_low_q  <= stored_low_q;
					edge_q     <= now;
				end
			end
			if (cmd.start) begin
				set_q <= 1'b0;
				clr_q <= 1'b0;
			end
			// toggle while the edge is still behind now
			if (cmd.step && en && d_q[31]) begin
				level_q <= ~level_q;
				if (level_q) begin
					clr_q <= 1'b1;
				end else begin
					set_q <= 1'b1;
				end
			end
			if (cmd.commit && en) begin
				edge_q <= now + d_q;
			end
		end
	end

	// distance to edge; disabled cells park at all ones so they never win the minimum
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			d_q <= en ? (edge_q - now) : '1;
		end else if (cmd.step && en && d_q[31]) begin
			d_q <= d_q + (level_q ? run_low_q : run_high_q);
		end
		min_q <= (d_q <= min_in) ? d_q : min_in;
	end

	assign min_out   = min_q;
	assign flags.set = set_q;
	assign flags.clr = clr_q;
	assign flags.lag = en & d_q[31];

	`MPS_ASSERT_NEXT(a_step_marks, cmd.step && en && d_q[31], set_q || clr_q,
		"catch-up toggle left no set or clear mark")
	`MPS_ASSERT_NEXT(a_restart_low, cmd.restart, !level_q,
		"restart did not clear the channel level")

endmodule

FILE: rtl/multichannel_pwm_scheduler.sv
// Tick with channels enabled: accept, then catch-up steps in S_STEP, then the minimum chain
// in S_REDUCE, then S_DONE, which loads the output register.
// Timing writes, restarts, idle ticks and unknown requests go from accept straight to S_DONE.
// One item in flight; the next is taken once the previous result sits in the output register.
// arst_n clears pins, levels and enables, sets all timings to DEFAULT_HALF, max_wait to 20000000.
// ----------------------------------------------------------------------------
// multichannel_pwm_scheduler
// Sequencer, enable/pin registers and output stage around a row of channel cells.
// ----------------------------------------------------------------------------
`include "multichannel_pwm_scheduler_assert.svh"

module multichannel_pwm_scheduler #(
	parameter int CHANNELS     = mps_pkg::CHANNELS_DEF,
	parameter int CATCHUP_MAX  = mps_pkg::CATCHUP_MAX_DEF,
	parameter int DEFAULT_HALF = mps_pkg::DEFAULT_HALF_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mps_pkg::mps_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output mps_pkg::mps_out_t out_data,
	input  logic              cfg_we,
	input  logic [30:0]       cfg_wdata
);

	localparam logic [31:0] CHAN_MASK = 32'((64'd1 << CHANNELS) - 64'd1);
	localparam int          CNT_MAX   = (CHANNELS > CATCHUP_MAX) ? CHANNELS : CATCHUP_MAX;
	localparam int          CNT_W     = $clog2(CNT_MAX + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_STEP   = 4'b0010,
		S_REDUCE = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [30:0]        max_wait_q;
	logic [31:0]        active_q, pin_q, now_q, next_q;
	logic               tick_q;
	logic               out_valid_q;
	mps_pkg::mps_out_t  out_q;

	logic               in_acc, out_ld, restart_acc, tick_run;
	mps_pkg::mps_cmd_t  cmd;
	logic [31:0]        now_bc, wr_low;
	logic [31:0]        cell_en, set_v, clr_v, lag_v;
	logic [31:0]        min_link [CHANNELS+1];

	assign in_stall    = (state_q != S_IDLE);
	assign in_acc      = in_valid && !in_stall;
	assign restart_acc = in_acc && (in_data.req_type == mps_pkg::REQ_RESTART);
	assign tick_run    = (in_data.req_type == mps_pkg::REQ_TICK) && (active_q != '0);
	assign out_ld      = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign cmd.restart = restart_acc;
	assign cmd.write   = in_acc && (in_data.req_type == mps_pkg::REQ_WRITE);
	assign cmd.start   = in_acc && tick_run;
	assign cmd.step    = (state_q == S_STEP);
	assign cmd.commit  = (state_q == S_REDUCE) && (cnt_q == '0);

	assign now_bc      = (state_q == S_IDLE) ? in_data.now : now_q;
	assign wr_low      = in_data.period - in_data.high_time;
	assign min_link[0] = {1'b0, max_wait_q};

	genvar gi;
	generate
		for (gi = 0; gi < 32; gi++) begin : g_lane
			if (gi < CHANNELS) begin : g_cell
				mps_pkg::mps_flags_t fl;
				assign cell_en[gi] = restart_acc ? in_data.enable_bits[gi] : active_q[gi];
				mps_cell #(
					.DEFAULT_HALF(DEFAULT_HALF)
				) u_cell (
					.clk    (clk),
					.arst_n (arst_n),
					.cmd    (cmd),
					.en     (cell_en[gi]),
					.wr_hit (in_data.channel == 5'(gi)),
					.wr_high(in_data.high_time),
					.wr_low (wr_low),
					.now    (now_bc),
					.min_in (min_link[gi]),
					.min_out(min_link[gi+1]),
					.flags  (fl)
				);
				assign set_v[gi] = fl.set;
				assign clr_v[gi] = fl.clr;
				assign lag_v[gi] = fl.lag;
			end else begin : g_none
				assign cell_en[gi] = 1'b0;
				assign set_v[gi]   = 1'b0;
				assign clr_v[gi]   = 1'b0;
				assign lag_v[gi]   = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			max_wait_q  <= mps_pkg::MAX_WAIT_RESET;
			active_q    <= '0;
			pin_q       <= '0;
			tick_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_wait_q <= cfg_wdata;
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						tick_q <= tick_run;
						cnt_q  <= '0;
						if (restart_acc) begin
							active_q <= in_data.enable_bits & CHAN_MASK;
						end
						state_q <= tick_run ? S_STEP : S_DONE;
					end
				end
				S_STEP: begin
					if (cnt_q == CNT_W'(CATCHUP_MAX - 1)) begin
						cnt_q   <= '0;
						state_q <= S_REDUCE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_REDUCE: begin
					if (cnt_q == CNT_W'(CHANNELS - 1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (out_ld) begin
						if (tick_q) begin
							pin_q <= (pin_q & ~clr_v) | set_v;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// beat payload and latched request fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q <= in_data.now;
			next_q <= (in_data.req_type == mps_pkg::REQ_TICK) ?
				in_data.now + {1'b0, max_wait_q} : in_data.now;
		end
		if (out_ld) begin
			out_q.enable_readback <= active_q;
			if (tick_q) begin
				out_q.pin_levels   <= (pin_q & ~clr_v) | set_v;
				out_q.pins_changed <= |(clr_v | set_v);
				out_q.next_event   <= now_q + min_link[CHANNELS];
				out_q.lagging      <= |lag_v;
			end else begin
				out_q.pin_levels   <= pin_q;
				out_q.pins_changed <= 1'b0;
				out_q.next_event   <= next_q;
				out_q.lagging      <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`MPS_ASSERT_NEXT(a_tick_start, in_acc && tick_run, state_q == S_STEP,
		"tick with enabled channels did not start catch-up")
	`MPS_ASSERT_SAME(a_lag_change, out_valid && out_data.lagging, out_data.pins_changed,
		"lagging reported without a pin change")
	`MPS_ASSERT_SAME(a_step_bound, state_q == S_STEP, cnt_q < CNT_W'(CATCHUP_MAX),
		"catch-up ran past its cap")
	`MPS_ASSERT_SAME(a_enable_range, out_valid, (out_data.enable_readback & ~CHAN_MASK) == '0,
		"enable mask holds a channel beyond the channel count")

endmodule
